FILE: src/frld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package frld_pkg;

  // accumulator and log datapath widths
  localparam int SUM_W      = 40;
  localparam int CFG_W      = 10;
  localparam int LOG_FRAC   = 24;
  localparam int ITER_W     = $clog2(LOG_FRAC);

  // 2560*log10(2) in Q.16
  localparam logic [31:0] LOG_K       = 32'd50504453;
  // log2(32768^2) = 30, in Q.24
  localparam logic [31:0] LOG_OFFSET  = 32'd503316480;
  // half of one output LSB in the Q.40 product
  localparam logic [63:0] ROUND_HALF  = 64'd549755813888;

  localparam int LEVEL_FLOOR          = -25600;
  localparam logic [CFG_W-1:0] FRAME_LENGTH_RESET = 10'd480;

  typedef logic signed [15:0] level_t;

endpackage

`default_nettype wire

FILE: src/frame_rms_level_dbfs.sv
`timescale 1ns / 1ps
`default_nettype none

// Frame RMS level meter, dBFS output in 1/256 dB.
//
// Input channel (in_valid/in_ready/sample): one signed 16-bit PCM sample
// per word. Each word is squared and added to a 40-bit running sum.
// Output channel (out_valid/out_ready/level_db_q8/silent): one word per
// frame, 20*log10(rms/32768) rounded half up, clamped to [-100, 0] dB.
// Config channel (cfg_valid/cfg_ready/frame_length): samples per frame,
// 0 acts as 1, values above MAX_FRAME_LENGTH saturate. Always ready.
//
// Sample handling: a sample that does not close a frame keeps the block
// busy while it is squared in the shared multiplier and then accumulated.
// A closing sample whose sum of squares is below the frame length gives a
// silent word at the floor; otherwise it starts the log sequence: two
// normalizations, two 24-step log2 iterations (one squaring in the shared
// 32x32 multiplier, one bit decision per step), then the scale multiply,
// rounding and clamp. The single multiplier serves all of these steps.
// Reset clears the sum and the sample count and drops any pending output
// word; the frame length returns to 480. A stalled receiver holds the
// result in the output register; samples are still taken until the next
// frame result is ready to be loaded, then input stalls until the old
// word is taken.
module frame_rms_level_dbfs
  import frld_pkg::*;
#(
  parameter int MAX_FRAME_LENGTH = 512
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire signed [15:0] sample,
  output logic             out_valid,
  input  wire              out_ready,
  output level_t           level_db_q8,
  output logic             silent,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire [CFG_W-1:0]  frame_length
);

  localparam int LEN_W = $clog2(MAX_FRAME_LENGTH + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  // sequencer codes
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_NORM  = 4'd3;
  localparam logic [3:0] S_MUL   = 4'd4;
  localparam logic [3:0] S_SQR   = 4'd5;
  localparam logic [3:0] S_DIFF  = 4'd6;
  localparam logic [3:0] S_ABS   = 4'd7;
  localparam logic [3:0] S_PMUL  = 4'd8;
  localparam logic [3:0] S_SIGN  = 4'd9;
  localparam logic [3:0] S_RND   = 4'd10;
  localparam logic [3:0] S_CLAMP = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]          state;
  logic [CFG_W-1:0]    frame_len;
  logic [SUM_W-1:0]    square_sum;
  logic [CFG_W-1:0]    sample_count;
  logic [LEN_W-1:0]    len;
  logic [SUM_W-1:0]    x;          // normalizer shift register
  logic [5:0]          e;          // exponent (top set bit index)
  logic [LOG_FRAC-1:0] frac;       // log2 fraction bits, MSB first
  logic [ITER_W-1:0]   iter;
  logic                on_len;     // second pass: log2 of the length
  logic [29:0]         log_s;
  logic [31:0]         m;          // Q1.31 mantissa, also |d| operand
  logic [63:0]         prod;
  logic [31:0]         d;
  logic                neg;
  logic signed [23:0]  lvl;
  level_t              res_level;
  logic                res_silent;

  logic [15:0]         mag;
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;
  logic [63:0]         mul_p;
  logic [CMP_W-1:0]    fl_ext;
  logic [CMP_W-1:0]    eff_ext;
  logic [LEN_W-1:0]    len_eff;
  logic [CFG_W-1:0]    cnt_inc;
  logic [63:0]         rnd;
  logic                load_out;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign mag       = sample[15] ? 16'(~$unsigned(sample) + 16'd1) : $unsigned(sample);

  // effective frame length: 0 acts as 1, saturate at the maximum
  always_comb begin
    fl_ext = CMP_W'(frame_len);
    if (fl_ext == '0) begin
      eff_ext = CMP_W'(1);
    end else if (fl_ext > CMP_W'(MAX_FRAME_LENGTH)) begin
      eff_ext = CMP_W'(MAX_FRAME_LENGTH);
    end else begin
      eff_ext = fl_ext;
    end
    len_eff = LEN_W'(eff_ext);
  end

  assign cnt_inc = sample_count + CFG_W'(1);

  // shared multiplier operand select
  always_comb begin
    case (state)
      S_IDLE: begin
        mul_a = {16'd0, mag};
        mul_b = {16'd0, mag};
      end
      S_PMUL: begin
        mul_a = m;
        mul_b = LOG_K;
      end
      default: begin
        mul_a = m;
        mul_b = m;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign rnd      = prod + ROUND_HALF;
  assign load_out = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_len    <= FRAME_LENGTH_RESET;
      square_sum   <= '0;
      sample_count <= '0;
      on_len       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        frame_len <= frame_length;
      end
      // in S_OUT the load below decides out_valid
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            prod  <= mul_p;
            state <= S_ACC;
          end
        end

        S_ACC: begin
          square_sum   <= square_sum + SUM_W'(prod[31:0]);
          sample_count <= cnt_inc;
          if (CMP_W'(cnt_inc) >= CMP_W'(len_eff)) begin
            len   <= len_eff;
            state <= S_CHK;
          end else begin
            state <= S_IDLE;
          end
        end

        S_CHK: begin
          if (square_sum < SUM_W'(len)) begin
            res_level  <= level_t'(LEVEL_FLOOR);
            res_silent <= 1'b1;
            state      <= S_OUT;
          end else begin
            x      <= square_sum;
            e      <= 6'(SUM_W - 1);
            on_len <= 1'b0;
            state  <= S_NORM;
          end
        end

        // coarse steps of 8, then single steps, until bit 39 is set
        S_NORM: begin
          if (x[SUM_W-1]) begin
            m     <= x[SUM_W-1 -: 32];
            iter  <= '0;
            state <= S_MUL;
          end else if (x[SUM_W-1 -: 8] == 8'd0) begin
            x <= {x[SUM_W-9:0], 8'd0};
            e <= e - 6'd8;
          end else begin
            x <= {x[SUM_W-2:0], 1'b0};
            e <= e - 6'd1;
          end
        end

        S_MUL: begin
          prod  <= mul_p;
          state <= S_SQR;
        end

        // square >= 2 in Q2.62 gives a 1 bit and a halving
        S_SQR: begin
          frac <= {frac[LOG_FRAC-2:0], prod[63]};
          m    <= prod[63] ? prod[63:32] : prod[62:31];
          iter <= iter + ITER_W'(1);
          if (iter == ITER_W'(LOG_FRAC - 1)) begin
            if (!on_len) begin
              log_s  <= {e, frac[LOG_FRAC-2:0], prod[63]};
              x      <= SUM_W'(len);
              e      <= 6'(SUM_W - 1);
              on_len <= 1'b1;
              state  <= S_NORM;
            end else begin
              state <= S_DIFF;
            end
          end else begin
            state <= S_MUL;
          end
        end

        S_DIFF: begin
          d     <= {2'b00, log_s} - {2'b00, e, frac} - LOG_OFFSET;
          state <= S_ABS;
        end

        S_ABS: begin
          m     <= d[31] ? (~d + 32'd1) : d;
          neg   <= d[31];
          state <= S_PMUL;
        end

        S_PMUL: begin
          prod  <= mul_p;
          state <= S_SIGN;
        end

        S_SIGN: begin
          prod  <= neg ? (~prod + 64'd1) : prod;
          state <= S_RND;
        end

        S_RND: begin
          lvl   <= $signed(rnd[63:40]);
          state <= S_CLAMP;
        end

        S_CLAMP: begin
          if (lvl < LEVEL_FLOOR) begin
            res_level <= level_t'(LEVEL_FLOOR);
          end else if (lvl > 0) begin
            res_level <= '0;
          end else begin
            res_level <= lvl[15:0];
          end
          res_silent <= 1'b0;
          state      <= S_OUT;
        end

        S_OUT: begin
          if (load_out) begin
            level_db_q8  <= res_level;
            silent       <= res_silent;
            out_valid    <= 1'b1;
            square_sum   <= '0;
            sample_count <= '0;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/frld_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module frld_checker
  import frld_pkg::*;
(
  input wire              clk,
  input wire              rst,
  input wire              in_valid,
  input wire              in_ready,
  input wire signed [15:0] sample,
  input wire              out_valid,
  input wire              out_ready,
  input wire signed [15:0] level_db_q8,
  input wire              silent
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(level_db_q8) && $stable(silent))
    else $error("result word changed while stalled");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level_db_q8 <= 0) && (level_db_q8 >= LEVEL_FLOOR))
    else $error("level outside clamp range");

  a_silent_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && silent |-> level_db_q8 == LEVEL_FLOOR)
    else $error("silent frame not at floor");

  // the block is busy accumulating after it takes a sample
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken during accumulate");

  // a waiting sample word holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(sample))
    else $error("sample word changed while waiting");

endmodule

bind frame_rms_level_dbfs frld_checker u_frld_checker (.*);

`default_nettype wire
